// ----- rtl/core/gfts_pkg.sv -----
// shared types, constants and the month table for the fix time segmenter
`timescale 1ns / 1ps
`default_nettype none

package gfts_pkg;

   localparam int SEC_W = 39;

   localparam int RECIP_25    = 2622;
   localparam int RECIP_SHIFT = 16;
   localparam int ERA_YEARS   = 400;
   localparam int YEAR_DAYS   = 365;
   localparam int ERA_DAYS    = 146097;
   localparam int EPOCH_DAYS  = 719468;
   localparam int DAY_HOURS   = 24;
   localparam int SIXTY       = 60;

   typedef enum logic [1:0] {
      CFG_GAP_LIMIT  = 2'd0,
      CFG_LOG_PERIOD = 2'd1,
      CFG_DUR_THRESH = 2'd2,
      CFG_DUR_EVERY  = 2'd3
   } cfg_index_type;

   typedef enum logic [2:0] {
      T_IDLE  = 3'b001,
      T_CONV  = 3'b010,
      T_CLOSE = 3'b100
   } top_state_type;

   typedef enum logic [7:0] {
      C_IDLE = 8'b0000_0001,
      C_ERA  = 8'b0000_0010,
      C_YOE  = 8'b0000_0100,
      C_DOE  = 8'b0000_1000,
      C_DAYS = 8'b0001_0000,
      C_HRS  = 8'b0010_0000,
      C_MINS = 8'b0100_0000,
      C_SECS = 8'b1000_0000
   } civ_state_type;

   // days from 1 march to the start of the month, march-based month index
   function automatic logic [8:0] days_before_month(input logic [3:0] mp);
      logic [8:0] d;
      begin
         unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            4'd12:   d = 9'd367;
            default: d = 9'd0;
         endcase
         return d;
      end
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gfts_civil.sv -----
// civil date and time to epoch seconds on one shared multiply-add unit
`timescale 1ns / 1ps
`default_nettype none

module gfts_civil (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [13:0]                    year,
   input  wire logic [3:0]                     month,
   input  wire logic [4:0]                     day,
   input  wire logic [4:0]                     hour,
   input  wire logic [5:0]                     minute,
   input  wire logic [5:0]                     second,
   output logic                                done,
   output logic signed [gfts_pkg::SEC_W-1:0]   secs
);

   gfts_pkg::civ_state_type state_ff, state_in;
   logic                            done_ff, done_in;
   logic signed [14:0]              ynum_ff, ynum_in;
   logic                            yneg_ff, yneg_in;
   logic [9:0]                      doy_ff, doy_in;
   logic [4:0]                      hour_ff, hour_in;
   logic [5:0]                      minute_ff, minute_in;
   logic [5:0]                      second_ff, second_in;
   logic signed [6:0]               era_ff, era_in;
   logic [gfts_pkg::SEC_W-1:0]      acc_ff, acc_in;

   logic                            early;
   logic [3:0]                      mp;
   logic signed [6:0]               era_val;
   logic [8:0]                      yoe;
   logic [1:0]                      div100;

   logic signed [gfts_pkg::SEC_W-1:0] mul_a;
   logic signed [18:0]                mul_b;
   logic [gfts_pkg::SEC_W-1:0]        mul_c;
   logic signed [57:0]                prod;

   assign early   = (month <= 4'd2);
   assign mp      = early ? (month + 4'd9) : (month - 4'd3);
   assign era_val = yneg_ff ? -7'sd1 : $signed({1'b0, acc_ff[gfts_pkg::RECIP_SHIFT +: 6]});
   assign yoe     = acc_ff[8:0];
   assign div100  = 2'(yoe >= 9'd100) + 2'(yoe >= 9'd200) + 2'(yoe >= 9'd300);

   // shared multiply-add
   assign prod   = mul_a * mul_b;
   assign acc_in = prod[gfts_pkg::SEC_W-1:0] + mul_c;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      mul_c = '0;
      unique case (state_ff)
         gfts_pkg::C_ERA: begin
            mul_a = gfts_pkg::SEC_W'(ynum_ff[13:4]);
            mul_b = 19'(gfts_pkg::RECIP_25);
         end
         gfts_pkg::C_YOE: begin
            mul_a = gfts_pkg::SEC_W'(era_val);
            mul_b = -19'(gfts_pkg::ERA_YEARS);
            mul_c = gfts_pkg::SEC_W'(ynum_ff);
         end
         gfts_pkg::C_DOE: begin
            mul_a = gfts_pkg::SEC_W'(yoe);
            mul_b = 19'(gfts_pkg::YEAR_DAYS);
            mul_c = gfts_pkg::SEC_W'(yoe[8:2]) - gfts_pkg::SEC_W'(div100)
                    + gfts_pkg::SEC_W'($signed(doy_ff));
         end
         gfts_pkg::C_DAYS: begin
            mul_a = gfts_pkg::SEC_W'(era_ff);
            mul_b = 19'(gfts_pkg::ERA_DAYS);
            mul_c = acc_ff - gfts_pkg::SEC_W'(gfts_pkg::EPOCH_DAYS);
         end
         gfts_pkg::C_HRS: begin
            mul_a = $signed(acc_ff);
            mul_b = 19'(gfts_pkg::DAY_HOURS);
            mul_c = gfts_pkg::SEC_W'(hour_ff);
         end
         gfts_pkg::C_MINS: begin
            mul_a = $signed(acc_ff);
            mul_b = 19'(gfts_pkg::SIXTY);
            mul_c = gfts_pkg::SEC_W'(minute_ff);
         end
         gfts_pkg::C_SECS: begin
            mul_a = $signed(acc_ff);
            mul_b = 19'(gfts_pkg::SIXTY);
            mul_c = gfts_pkg::SEC_W'(second_ff);
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      done_in   = done_ff;
      ynum_in   = ynum_ff;
      yneg_in   = yneg_ff;
      doy_in    = doy_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      era_in    = era_ff;
      unique case (state_ff)
         gfts_pkg::C_IDLE: begin
            if (start) begin
               state_in  = gfts_pkg::C_ERA;
               done_in   = 1'b0;
               ynum_in   = $signed({1'b0, year}) - $signed(15'(early));
               yneg_in   = early && (year == 14'd0);
               doy_in    = 10'(gfts_pkg::days_before_month(mp)) + 10'(day) - 10'd1;
               hour_in   = hour;
               minute_in = minute;
               second_in = second;
            end
         end
         gfts_pkg::C_ERA:  state_in = gfts_pkg::C_YOE;
         gfts_pkg::C_YOE: begin
            era_in   = era_val;
            state_in = gfts_pkg::C_DOE;
         end
         gfts_pkg::C_DOE:  state_in = gfts_pkg::C_DAYS;
         gfts_pkg::C_DAYS: state_in = gfts_pkg::C_HRS;
         gfts_pkg::C_HRS:  state_in = gfts_pkg::C_MINS;
         gfts_pkg::C_MINS: state_in = gfts_pkg::C_SECS;
         gfts_pkg::C_SECS: begin
            done_in  = 1'b1;
            state_in = gfts_pkg::C_IDLE;
         end
         default: state_in = gfts_pkg::C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfts_pkg::C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      ynum_ff   <= ynum_in;
      yneg_ff   <= yneg_in;
      doy_ff    <= doy_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
      second_ff <= second_in;
      era_ff    <= era_in;
      if (state_ff != gfts_pkg::C_IDLE) begin
         acc_ff <= acc_in;
      end
   end

   assign done = done_ff;
   assign secs = $signed(acc_ff);

endmodule

`default_nettype wire

// ----- rtl/core/gps_fix_time_segmenter.sv -----
// top level of the gps fix time segmenter: track state, csr block and result register
// an add runs seven multiply-add passes and then writes its result to the result register,
// and a close writes its result register directly; a stalled output holds back either one,
// and the input stalls while an item is in work, which lasts until its result is registered,
// so a new add or close is taken only once the last one is through
// reset: synchronous, clears the track and loads the csr defaults; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module gps_fix_time_segmenter (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [0:0]                     req_opcode,
   input  wire logic [13:0]                    req_year,
   input  wire logic [3:0]                     req_month,
   input  wire logic [4:0]                     req_day,
   input  wire logic [4:0]                     req_hour,
   input  wire logic [5:0]                     req_minute,
   input  wire logic [5:0]                     req_second,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic signed [gfts_pkg::SEC_W-1:0]   rsp_epoch_seconds,
   output logic                                rsp_track_opened,
   output logic                                rsp_segment_break,
   output logic                                rsp_durable_flush,
   output logic [31:0]                         rsp_point_count,
   output logic                                rsp_track_closed,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [3:0]                     paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   gfts_pkg::top_state_type state_ff, state_in;

   logic [15:0] gap_ff, gap_in;
   logic [15:0] logp_ff, logp_in;
   logic [15:0] thr_ff, thr_in;
   logic [7:0]  every_ff, every_in;

   logic                              open_ff, open_in;
   logic signed [gfts_pkg::SEC_W-1:0] last_ff, last_in;
   logic [31:0]                       pts_ff, pts_in;
   logic [7:0]                        psd_ff, psd_in;

   logic                              out_valid_ff, out_valid_in;
   logic signed [gfts_pkg::SEC_W-1:0] out_secs_ff, out_secs_in;
   logic                              out_opened_ff, out_opened_in;
   logic                              out_brk_ff, out_brk_in;
   logic                              out_dur_ff, out_dur_in;
   logic [31:0]                       out_count_ff, out_count_in;
   logic                              out_closed_ff, out_closed_in;

   logic                              accept;
   logic                              csr_write;
   logic                              out_free;
   logic                              emit_add;
   logic                              emit_close;
   logic                              civ_done;
   logic signed [gfts_pkg::SEC_W-1:0] civ_secs;

   logic signed [gfts_pkg::SEC_W-1:0] base_last;
   logic signed [gfts_pkg::SEC_W:0]   delta;
   logic                              brk;
   logic [31:0]                       pts_next;
   logic [7:0]                        psd_next;
   logic                              every_hit;
   logic                              durable;

   assign req_stall = (state_ff != gfts_pkg::T_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;
   assign out_free  = !out_valid_ff || !rsp_stall;

   gfts_civil u_civil (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && (req_opcode == 1'b0)),
      .year   (req_year),
      .month  (req_month),
      .day    (req_day),
      .hour   (req_hour),
      .minute (req_minute),
      .second (req_second),
      .done   (civ_done),
      .secs   (civ_secs)
   );

   // per-fix track decisions
   assign base_last = open_ff ? last_ff : '0;
   assign delta     = (gfts_pkg::SEC_W + 1)'(civ_secs) - (gfts_pkg::SEC_W + 1)'(base_last);
   assign brk       = (base_last != '0)
                      && ((delta < 0) || (delta > $signed((gfts_pkg::SEC_W + 1)'(gap_ff))));
   assign pts_next  = (open_ff ? pts_ff : 32'd0) + 32'd1;
   assign psd_next  = (open_ff ? psd_ff : 8'd0) + 8'd1;
   assign every_hit = (psd_next >= every_ff);
   assign durable   = every_hit || (logp_ff >= thr_ff);

   assign emit_add   = (state_ff == gfts_pkg::T_CONV) && civ_done && out_free;
   assign emit_close = (state_ff == gfts_pkg::T_CLOSE) && out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gfts_pkg::T_IDLE: begin
            if (accept) begin
               state_in = (req_opcode == 1'b0) ? gfts_pkg::T_CONV : gfts_pkg::T_CLOSE;
            end
         end
         gfts_pkg::T_CONV: begin
            if (emit_add) begin
               state_in = gfts_pkg::T_IDLE;
            end
         end
         gfts_pkg::T_CLOSE: begin
            if (emit_close) begin
               state_in = gfts_pkg::T_IDLE;
            end
         end
         default: state_in = gfts_pkg::T_IDLE;
      endcase
   end

   always_comb begin
      gap_in   = gap_ff;
      logp_in  = logp_ff;
      thr_in   = thr_ff;
      every_in = every_ff;
      if (csr_write) begin
         unique case (paddr[3:2])
            gfts_pkg::CFG_GAP_LIMIT:  gap_in   = pwdata[15:0];
            gfts_pkg::CFG_LOG_PERIOD: logp_in  = pwdata[15:0];
            gfts_pkg::CFG_DUR_THRESH: thr_in   = pwdata[15:0];
            gfts_pkg::CFG_DUR_EVERY:  every_in = pwdata[7:0];
            default:                  gap_in   = gap_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         gfts_pkg::CFG_GAP_LIMIT:  prdata = 32'(gap_ff);
         gfts_pkg::CFG_LOG_PERIOD: prdata = 32'(logp_ff);
         gfts_pkg::CFG_DUR_THRESH: prdata = 32'(thr_ff);
         gfts_pkg::CFG_DUR_EVERY:  prdata = 32'(every_ff);
         default:                  prdata = '0;
      endcase
   end

   always_comb begin
      open_in       = open_ff;
      last_in       = last_ff;
      pts_in        = pts_ff;
      psd_in        = psd_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_secs_in   = out_secs_ff;
      out_opened_in = out_opened_ff;
      out_brk_in    = out_brk_ff;
      out_dur_in    = out_dur_ff;
      out_count_in  = out_count_ff;
      out_closed_in = out_closed_ff;
      priority if (emit_add) begin
         open_in       = 1'b1;
         last_in       = civ_secs;
         pts_in        = pts_next;
         psd_in        = every_hit ? 8'd0 : psd_next;
         out_valid_in  = 1'b1;
         out_secs_in   = civ_secs;
         out_opened_in = !open_ff;
         out_brk_in    = brk;
         out_dur_in    = durable;
         out_count_in  = pts_next;
         out_closed_in = 1'b0;
      end else if (emit_close) begin
         open_in       = 1'b0;
         last_in       = '0;
         pts_in        = '0;
         psd_in        = '0;
         out_valid_in  = 1'b1;
         out_secs_in   = '0;
         out_opened_in = 1'b0;
         out_brk_in    = 1'b0;
         out_dur_in    = 1'b0;
         out_count_in  = '0;
         out_closed_in = open_ff;
      end else begin
         open_in = open_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gfts_pkg::T_IDLE;
         gap_ff       <= 16'd30;
         logp_ff      <= 16'd1;
         thr_ff       <= 16'd10;
         every_ff     <= 8'd5;
         open_ff      <= 1'b0;
         last_ff      <= '0;
         pts_ff       <= '0;
         psd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gap_ff       <= gap_in;
         logp_ff      <= logp_in;
         thr_ff       <= thr_in;
         every_ff     <= every_in;
         open_ff      <= open_in;
         last_ff      <= last_in;
         pts_ff       <= pts_in;
         psd_ff       <= psd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_secs_ff   <= out_secs_in;
      out_opened_ff <= out_opened_in;
      out_brk_ff    <= out_brk_in;
      out_dur_ff    <= out_dur_in;
      out_count_ff  <= out_count_in;
      out_closed_ff <= out_closed_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_epoch_seconds = out_secs_ff;
   assign rsp_track_opened  = out_opened_ff;
   assign rsp_segment_break = out_brk_ff;
   assign rsp_durable_flush = out_dur_ff;
   assign rsp_point_count   = out_count_ff;
   assign rsp_track_closed  = out_closed_ff;

endmodule

`default_nettype wire
